>>> sv/tmr_pkg.sv
// Shared types and codes for the three-channel interval timer.
// No dependencies; used by tmr_chan and three_channel_interval_timer.
package tmr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_GATE  = 2'd3
  } op_t;

  localparam logic [1:0] PORT_CONTROL = 2'd3;

  localparam logic [1:0] ACC_LATCH = 2'd0;
  localparam logic [1:0] ACC_LOW   = 2'd1;
  localparam logic [1:0] ACC_HIGH  = 2'd2;
  localparam logic [1:0] ACC_BOTH  = 2'd3;

  localparam logic [2:0] CM_INT_ON_TC   = 3'd0;
  localparam logic [2:0] CM_ONE_SHOT    = 3'd1;
  localparam logic [2:0] CM_SQUARE      = 3'd3;
  localparam logic [2:0] CM_SW_STROBE   = 3'd4;
  localparam logic [2:0] CM_HW_STROBE   = 3'd5;
  localparam logic [2:0] CM_SQUARE_ALT  = 3'd7;

  localparam logic [7:0]  CTRL_READ_BYTE = 8'hFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] port;
    logic [7:0] data_byte;
    logic [1:0] gate_channel;
    logic       gate_level;
  } tmr_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_zero;
    logic       out_one;
    logic       out_two;
    logic       bad_channel;
  } tmr_out_t;

  // per-channel command for one word
  typedef struct packed {
    logic       ctl_wr;
    logic       data_wr;
    logic       data_rd;
    logic       tick;
    logic       gate;
    logic       gate_level;
    logic [7:0] data;
  } tmr_cmd_t;

endpackage

>>> sv/tmr_chan.sv
// One 16-bit counter channel: access/count modes, reload, gate and tick logic.
// Depends on tmr_pkg.
module tmr_chan
  import tmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  tmr_cmd_t cmd,
  output logic [7:0] rd_byte,
  output logic     level_next
);

  logic [1:0]  access_mode, access_mode_next;
  logic        byte_toggle, byte_toggle_next;
  logic [2:0]  count_mode, count_mode_next;
  logic [15:0] reload_value, reload_value_next;
  logic [15:0] count_value, count_value_next;
  logic        running, running_next;
  logic        out_level, out_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      access_mode  <= ACC_LATCH;
      byte_toggle  <= 1'b0;
      count_mode   <= CM_INT_ON_TC;
      reload_value <= '0;
      count_value  <= '0;
      running      <= 1'b0;
      out_level    <= 1'b0;
    end else begin
      access_mode  <= access_mode_next;
      byte_toggle  <= byte_toggle_next;
      count_mode   <= count_mode_next;
      reload_value <= reload_value_next;
      count_value  <= count_value_next;
      running      <= running_next;
      out_level    <= out_level_next;
    end
  end

  always_comb begin
    logic [7:0] lo, hi;
    logic       m04;
    logic       cnt_zero;
    lo       = reload_value[7:0];
    hi       = reload_value[15:8];
    m04      = (count_mode == CM_INT_ON_TC) || (count_mode == CM_SW_STROBE);
    cnt_zero = (count_value == 16'd0);

    access_mode_next  = access_mode;
    byte_toggle_next  = byte_toggle;
    count_mode_next   = count_mode;
    reload_value_next = reload_value;
    count_value_next  = count_value;
    running_next      = running;
    out_level_next    = out_level;

    case (access_mode)
      ACC_HIGH: rd_byte = count_value[15:8];
      ACC_BOTH: rd_byte = byte_toggle ? count_value[15:8] : count_value[7:0];
      default:  rd_byte = count_value[7:0];
    endcase

    if (cmd.ctl_wr) begin
      count_mode_next  = cmd.data[3:1];
      access_mode_next = cmd.data[5:4];
      if ((cmd.data[3:1] == CM_INT_ON_TC) || (cmd.data[3:1] == CM_SW_STROBE)) begin
        count_value_next = count_value - 16'd1;
        running_next     = 1'b1;
      end
    end

    if (cmd.data_wr) begin
      case (access_mode)
        ACC_LOW:  lo = cmd.data;
        ACC_HIGH: hi = cmd.data;
        ACC_BOTH: begin
          if (!byte_toggle) begin
            lo = cmd.data;
            byte_toggle_next = 1'b1;
            if (count_mode == CM_INT_ON_TC) running_next = 1'b0;
          end else begin
            hi = cmd.data;
            byte_toggle_next = 1'b0;
            if (m04) running_next = 1'b1;
          end
        end
        default: ;
      endcase
      reload_value_next = {hi, lo};
      if (m04) count_value_next = {hi, lo};
    end

    if (cmd.data_rd && (access_mode == ACC_BOTH)) begin
      byte_toggle_next = !byte_toggle;
    end

    if (cmd.tick && running) begin
      case (count_mode)
        CM_INT_ON_TC, CM_ONE_SHOT: begin
          if (cnt_zero) begin
            out_level_next = 1'b1;
            if (count_mode == CM_INT_ON_TC) begin
              reload_value_next = '0;
              count_value_next  = COUNT_MAX;
            end else begin
              count_value_next = reload_value;
              running_next     = 1'b0;
            end
          end else begin
            out_level_next   = 1'b0;
            count_value_next = count_value - 16'd1;
          end
        end
        CM_SQUARE, CM_SQUARE_ALT: begin
          if (cnt_zero) begin
            out_level_next   = 1'b1;
            count_value_next = reload_value;
          end else begin
            out_level_next   = !(count_value <= {1'b0, reload_value[15:1]});
            count_value_next = count_value - 16'd1;
          end
        end
        default: begin
          if (cnt_zero) begin
            out_level_next = 1'b1;
            if (count_mode == CM_SW_STROBE) begin
              reload_value_next = '0;
              count_value_next  = '0;
            end else begin
              count_value_next = reload_value;
            end
            if ((count_mode == CM_SW_STROBE) || (count_mode == CM_HW_STROBE)) begin
              running_next = 1'b0;
            end
          end else begin
            out_level_next   = (count_value != 16'd1);
            count_value_next = count_value - 16'd1;
          end
        end
      endcase
    end

    if (cmd.gate) begin
      if (!cmd.gate_level) begin
        running_next = 1'b0;
      end else begin
        running_next = 1'b1;
        if (reload_value != 16'd0) count_value_next = reload_value;
      end
    end

    level_next = out_level_next;
  end

endmodule

>>> sv/three_channel_interval_timer.sv
// Three-channel interval timer top level: input register, command decode,
// channel instances and result register. Depends on tmr_pkg and tmr_chan.
//
// Each accepted word yields one result word. The word is held in the input
// register until it fires; the channels update and the result register loads
// at the same edge. A new word is taken every cycle while results are drained.
// The input side stalls only when the result register is full and stalled.
module three_channel_interval_timer
  import tmr_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  tmr_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output tmr_out_t out_word
);

  logic     inq_valid;
  tmr_in_t  inq;
  logic     fire;
  logic     tick_phase;
  logic     tick_en;
  logic     bad;
  logic [7:0] read_data;
  logic [7:0] rd_bytes [4];
  logic       levels [3];

  assign fire     = inq_valid && (!out_valid || !out_stall);
  assign in_stall = inq_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (!in_stall) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq <= in_word;
    end
  end

  assign tick_en = fire && (inq.op == OP_TICK) && !tick_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase <= 1'b0;
    end else if (fire && (inq.op == OP_TICK)) begin
      tick_phase <= !tick_phase;
    end
  end

  assign rd_bytes[3] = '0;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    if (i < NUM_CHANNELS) begin : g_on
      tmr_cmd_t cmd;
      always_comb begin
        cmd.ctl_wr     = fire && (inq.op == OP_WRITE) && (inq.port == PORT_CONTROL) &&
                         (inq.data_byte[7:6] == 2'(i));
        cmd.data_wr    = fire && (inq.op == OP_WRITE) && (inq.port == 2'(i));
        cmd.data_rd    = fire && (inq.op == OP_READ) && (inq.port == 2'(i));
        cmd.tick       = tick_en;
        cmd.gate       = fire && (inq.op == OP_GATE) && (inq.gate_channel == 2'(i));
        cmd.gate_level = inq.gate_level;
        cmd.data       = inq.data_byte;
      end
      tmr_chan u_chan (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .rd_byte    (rd_bytes[i]),
        .level_next (levels[i])
      );
    end else begin : g_off
      assign rd_bytes[i] = '0;
      assign levels[i]   = 1'b0;
    end
  end

  always_comb begin
    bad = (inq.op == OP_WRITE) && (inq.port == PORT_CONTROL) &&
          (32'(inq.data_byte[7:6]) >= NUM_CHANNELS);
    read_data = '0;
    if (inq.op == OP_READ) begin
      read_data = (inq.port == PORT_CONTROL) ? CTRL_READ_BYTE : rd_bytes[inq.port];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word.read_data   <= read_data;
      out_word.out_zero    <= levels[0];
      out_word.out_one     <= levels[1];
      out_word.out_two     <= levels[2];
      out_word.bad_channel <= bad;
    end
  end

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted word did not produce a result");

  a_stall_needs_held_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (inq_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_tick_phase_toggles: assert property (@(posedge clk) disable iff (rst)
    (fire && (inq.op == OP_TICK)) |=> (tick_phase != $past(tick_phase)))
    else $error("tick did not toggle phase");

  a_bad_has_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.bad_channel && (out_word.read_data != 8'd0)))
    else $error("bad channel result carries read data");

endmodule
